[hdl/sfq_pkg.sv]
// Shared types and constants for the seen-filter event queue.
// Holds the command and status codes, the seen-table handshake structs
// and the default sizes. No dependencies.
package sfq_pkg;

  localparam int unsigned SEEN_DEPTH_DEF   = 32;
  localparam int unsigned QUEUE_DEPTH_DEF  = 8;
  localparam int unsigned KEY_BITS_DEF     = 64;
  localparam int unsigned PAYLOAD_BITS_DEF = 32;

  typedef enum logic [1:0] {
    CMD_ENQUEUE     = 2'd0,
    CMD_DEQUEUE     = 2'd1,
    CMD_CLEAR_QUEUE = 2'd2,
    CMD_CLEAR_SEEN  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK          = 2'd0,
    STS_EMPTY_KEY   = 2'd1,
    STS_SEEN        = 2'd2,
    STS_QUEUE_EMPTY = 2'd3
  } status_e;

  // Request from the sequencer to the seen table.
  typedef struct packed {
    logic lookup;  // start a scan for the presented key
    logic record;  // on a miss, store the key in the ring
    logic clear;   // forget all seen keys
  } seen_req_t;

  // Answer from the seen table, valid for one cycle.
  typedef struct packed {
    logic done;
    logic hit;
  } seen_rsp_t;

endpackage

[hdl/sfq_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
// Used for the seen ring and the event queue. No dependencies.
module sfq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/sfq_seen.sv]
// Seen-key ring: a RAM of recent keys with a write pointer and a saturating
// fill count, and a scanner that compares one stored key per cycle.
// Depends on sfq_pkg and sfq_ram.
module sfq_seen #(
  parameter int unsigned SEEN_DEPTH = sfq_pkg::SEEN_DEPTH_DEF,
  parameter int unsigned KEY_BITS   = sfq_pkg::KEY_BITS_DEF,
  localparam int unsigned SW = $clog2(SEEN_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sfq_pkg::seen_req_t  req_i,
  input  logic [KEY_BITS-1:0] key_i,
  output sfq_pkg::seen_rsp_t  rsp_o,
  output logic [SW-1:0]       count_o
);

  import sfq_pkg::*;

  localparam int unsigned SA = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e              state_q;
  logic [KEY_BITS-1:0] key_q;
  logic                record_q;
  logic [SW-1:0]       issue_idx_q;
  logic                pend_q;
  logic [SA-1:0]       pos_q;
  logic [SW-1:0]       count_q;

  logic [KEY_BITS-1:0] rd_key;
  logic                more;
  logic                hit_now;
  logic                done;
  logic                ram_we;

  // A read is issued for every index below the count; its data is compared
  // in the next cycle while the next read is already under way.
  assign more    = issue_idx_q < count_q;
  assign hit_now = pend_q && (rd_key == key_q);
  assign done    = (state_q == S_SCAN) && (hit_now || !more);
  assign ram_we  = done && !hit_now && record_q && (key_q != '0);

  assign rsp_o.done = done;
  assign rsp_o.hit  = hit_now;
  assign count_o    = count_q;

  sfq_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(SEEN_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pos_q),
    .wdata_i(key_q),
    .raddr_i(issue_idx_q[SA-1:0]),
    .rdata_o(rd_key)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      key_q       <= '0;
      record_q    <= 1'b0;
      issue_idx_q <= '0;
      pend_q      <= 1'b0;
      pos_q       <= '0;
      count_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_i.clear) begin
            pos_q   <= '0;
            count_q <= '0;
          end
          if (req_i.lookup) begin
            key_q       <= key_i;
            record_q    <= req_i.record;
            issue_idx_q <= '0;
            pend_q      <= 1'b0;
            state_q     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (done) begin
            pend_q  <= 1'b0;
            state_q <= S_IDLE;
            if (ram_we) begin
              pos_q <= (pos_q == SA'(SEEN_DEPTH - 1)) ? '0 : pos_q + 1'b1;
              if (count_q != SW'(SEEN_DEPTH)) begin
                count_q <= count_q + 1'b1;
              end
            end
          end else begin
            pend_q <= more;
            if (more) begin
              issue_idx_q <= issue_idx_q + 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SW'(SEEN_DEPTH))
    else $error("seen count above table depth");

  // Until the ring has wrapped, the write pointer equals the fill count.
  a_pos_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q < SW'(SEEN_DEPTH)) |-> (SW'(pos_q) == count_q))
    else $error("seen write pointer out of step with count");

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !(req_i.lookup || req_i.clear))
    else $error("seen table request while a scan is running");
`endif

endmodule

[hdl/seen_filter_event_queue_top.sv]
// Top level of the seen-filter event queue: command sequencer, event FIFO
// in a RAM, and the output register. Depends on sfq_pkg, sfq_ram, sfq_seen.
//
// Usage: one command item enters on in_valid_i/in_stall_o with command_i,
// event_key_i and event_payload_i; exactly one result item leaves on
// out_valid_o/out_stall_i. Enqueue checks the key against the seen ring,
// which is scanned one stored key per cycle; dequeue reads the FIFO head
// and then scans the ring, recording the key if it was not there yet.
// Clear commands and rejected items (empty key, empty queue) go from
// acceptance straight to the finish state; an enqueue passes through the
// seen scan, a dequeue through the FIFO read and the seen scan. A scan
// that finds the key ends early. One item is in work at a time; in_stall_o
// is high while it is, and a new item can be taken while the last result
// still waits in the output register. If the receiver stalls, the result
// is held and the sequencer waits once it has the next result ready.
// Reset empties the queue and the seen ring at once; no clearing pass.
module seen_filter_event_queue_top #(
  parameter int unsigned SEEN_DEPTH   = sfq_pkg::SEEN_DEPTH_DEF,
  parameter int unsigned QUEUE_DEPTH  = sfq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned KEY_BITS     = sfq_pkg::KEY_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = sfq_pkg::PAYLOAD_BITS_DEF,
  localparam int unsigned QW = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned SW = $clog2(SEEN_DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              command_i,
  input  logic [KEY_BITS-1:0]     event_key_i,
  input  logic [PAYLOAD_BITS-1:0] event_payload_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              status_o,
  output logic                    success_o,
  output logic                    dropped_oldest_o,
  output logic [KEY_BITS-1:0]     out_key_o,
  output logic [PAYLOAD_BITS-1:0] out_payload_o,
  output logic [QW-1:0]           queued_total_o,
  output logic [SW-1:0]           seen_total_o
);

  import sfq_pkg::*;

  localparam int unsigned QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned EW = KEY_BITS + PAYLOAD_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QREAD,
    ST_SEEN,
    ST_FINISH
  } state_e;

  state_e                  state_q;
  cmd_e                    cmd_q;
  logic [KEY_BITS-1:0]     key_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [QA-1:0]           head_q;
  logic [QA-1:0]           tail_q;
  logic [QW-1:0]           fill_q;
  status_e                 res_status_q;
  logic                    res_success_q;
  logic                    res_dropped_q;
  logic [KEY_BITS-1:0]     res_key_q;
  logic [PAYLOAD_BITS-1:0] res_pay_q;
  logic                    out_valid_q;
  status_e                 out_status_q;
  logic                    out_success_q;
  logic                    out_dropped_q;
  logic [KEY_BITS-1:0]     out_key_q;
  logic [PAYLOAD_BITS-1:0] out_pay_q;
  logic [QW-1:0]           out_qtotal_q;
  logic [SW-1:0]           out_stotal_q;

  cmd_e                    cmd_in;
  logic                    accept;
  logic                    out_free;
  logic                    queue_full;
  logic                    q_we;
  logic [EW-1:0]           q_rdata;
  logic [KEY_BITS-1:0]     q_rd_key;
  logic [PAYLOAD_BITS-1:0] q_rd_pay;
  seen_req_t               seen_req;
  seen_rsp_t               seen_rsp;
  logic [KEY_BITS-1:0]     seen_key;
  logic [SW-1:0]           seen_count;

  assign cmd_in     = cmd_e'(command_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign queue_full = (fill_q == QW'(QUEUE_DEPTH));
  assign q_rd_key   = q_rdata[EW-1:PAYLOAD_BITS];
  assign q_rd_pay   = q_rdata[PAYLOAD_BITS-1:0];
  assign q_we       = (state_q == ST_SEEN) && seen_rsp.done && (cmd_q == CMD_ENQUEUE)
                      && !seen_rsp.hit;

  // The dequeue path starts its seen scan with the key just read from the FIFO.
  assign seen_req.lookup = (accept && (cmd_in == CMD_ENQUEUE) && (event_key_i != '0))
                           || (state_q == ST_QREAD);
  assign seen_req.record = (state_q == ST_QREAD);
  assign seen_req.clear  = accept && (cmd_in == CMD_CLEAR_SEEN);
  assign seen_key        = (state_q == ST_QREAD) ? q_rd_key : event_key_i;

  sfq_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (q_we),
    .waddr_i(tail_q),
    .wdata_i({key_q, pay_q}),
    .raddr_i(head_q),
    .rdata_o(q_rdata)
  );

  sfq_seen #(
    .SEEN_DEPTH(SEEN_DEPTH),
    .KEY_BITS  (KEY_BITS)
  ) u_seen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (seen_req),
    .key_i  (seen_key),
    .rsp_o  (seen_rsp),
    .count_o(seen_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cmd_q         <= CMD_ENQUEUE;
      key_q         <= '0;
      pay_q         <= '0;
      head_q        <= '0;
      tail_q        <= '0;
      fill_q        <= '0;
      res_status_q  <= STS_OK;
      res_success_q <= 1'b0;
      res_dropped_q <= 1'b0;
      res_key_q     <= '0;
      res_pay_q     <= '0;
      out_valid_q   <= 1'b0;
      out_status_q  <= STS_OK;
      out_success_q <= 1'b0;
      out_dropped_q <= 1'b0;
      out_key_q     <= '0;
      out_pay_q     <= '0;
      out_qtotal_q  <= '0;
      out_stotal_q  <= '0;
    end else begin
      // In the finish state the output register is reloaded instead.
      if (out_valid_q && !out_stall_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cmd_q         <= cmd_in;
            key_q         <= event_key_i;
            pay_q         <= event_payload_i;
            res_success_q <= 1'b0;
            res_dropped_q <= 1'b0;
            res_key_q     <= '0;
            res_pay_q     <= '0;
            unique case (cmd_in)
              CMD_ENQUEUE: begin
                if (event_key_i == '0) begin
                  res_status_q <= STS_EMPTY_KEY;
                  state_q      <= ST_FINISH;
                end else begin
                  res_status_q <= STS_OK;
                  state_q      <= ST_SEEN;
                end
              end
              CMD_DEQUEUE: begin
                if (fill_q == '0) begin
                  res_status_q <= STS_QUEUE_EMPTY;
                  state_q      <= ST_FINISH;
                end else begin
                  res_status_q <= STS_OK;
                  state_q      <= ST_QREAD;
                end
              end
              CMD_CLEAR_QUEUE: begin
                res_status_q <= STS_OK;
                head_q       <= '0;
                tail_q       <= '0;
                fill_q       <= '0;
                state_q      <= ST_FINISH;
              end
              CMD_CLEAR_SEEN: begin
                res_status_q <= STS_OK;
                state_q      <= ST_FINISH;
              end
              default: begin
                res_status_q <= STS_OK;
                state_q      <= ST_FINISH;
              end
            endcase
          end
        end
        ST_QREAD: begin
          res_key_q     <= q_rd_key;
          res_pay_q     <= q_rd_pay;
          res_success_q <= 1'b1;
          head_q        <= (head_q == QA'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
          fill_q        <= fill_q - 1'b1;
          state_q       <= ST_SEEN;
        end
        ST_SEEN: begin
          if (seen_rsp.done) begin
            state_q <= ST_FINISH;
            if (cmd_q == CMD_ENQUEUE) begin
              if (seen_rsp.hit) begin
                res_status_q <= STS_SEEN;
              end else begin
                res_success_q <= 1'b1;
                tail_q <= (tail_q == QA'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
                // A full queue loses its oldest item; the fill stays put.
                if (queue_full) begin
                  res_dropped_q <= 1'b1;
                  head_q <= (head_q == QA'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
                end else begin
                  fill_q <= fill_q + 1'b1;
                end
              end
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_status_q  <= res_status_q;
            out_success_q <= res_success_q;
            out_dropped_q <= res_dropped_q;
            out_key_q     <= res_key_q;
            out_pay_q     <= res_pay_q;
            out_qtotal_q  <= fill_q;
            out_stotal_q  <= seen_count;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign success_o        = out_success_q;
  assign dropped_oldest_o = out_dropped_q;
  assign out_key_o        = out_key_q;
  assign out_payload_o    = out_pay_q;
  assign queued_total_o   = out_qtotal_q;
  assign seen_total_o     = out_stotal_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= QW'(QUEUE_DEPTH))
    else $error("queue fill above depth");

  a_drop_implies_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dropped_oldest_o)
      |-> (success_o && (queued_total_o == QW'(QUEUE_DEPTH))))
    else $error("dropped oldest without a full queue");

  a_success_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && success_o) |-> (status_o == STS_OK))
    else $error("successful item with an error status");

  a_seen_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_rsp.done |-> (state_q == ST_SEEN))
    else $error("seen table answered outside of a scan");
`endif

endmodule

[dv/seen_filter_event_queue_top_test.sv]
// Self-checking bench for seen_filter_event_queue_top: directed and random
// command items with random gaps and stalls, checked against a local tracker.
// Depends on sfq_pkg and the RTL of the block.
module seen_filter_event_queue_top_test;
  import sfq_pkg::*;

  localparam int QDEPTH   = QUEUE_DEPTH_DEF;
  localparam int SDEPTH   = SEEN_DEPTH_DEF;
  localparam int KBITS    = KEY_BITS_DEF;
  localparam int PBITS    = PAYLOAD_BITS_DEF;
  localparam int QW       = $clog2(QDEPTH + 1);
  localparam int SW       = $clog2(SDEPTH + 1);
  localparam int N_RANDOM = 1750;
  localparam int POOL     = 48;

  typedef struct {
    cmd_e             cmd;
    logic [KBITS-1:0] key;
    logic [PBITS-1:0] pay;
    bit               drain;
  } cmd_item_t;

  typedef struct {
    status_e          status;
    logic             success;
    logic             dropped;
    logic [KBITS-1:0] key;
    logic [PBITS-1:0] pay;
    logic [QW-1:0]    queued;
    logic [SW-1:0]    seen;
  } track_result_t;

  logic                 clk_i;
  logic                 rst_ni          = 1'b0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           command_i       = CMD_ENQUEUE;
  logic [KBITS-1:0]     event_key_i     = '0;
  logic [PBITS-1:0]     event_payload_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [1:0]           status_o;
  logic                 success_o;
  logic                 dropped_oldest_o;
  logic [KBITS-1:0]     out_key_o;
  logic [PBITS-1:0]     out_payload_o;
  logic [QW-1:0]        queued_total_o;
  logic [SW-1:0]        seen_total_o;

  seen_filter_event_queue_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .event_key_i      (event_key_i),
    .event_payload_i  (event_payload_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .success_o        (success_o),
    .dropped_oldest_o (dropped_oldest_o),
    .out_key_o        (out_key_o),
    .out_payload_o    (out_payload_o),
    .queued_total_o   (queued_total_o),
    .seen_total_o     (seen_total_o)
  );

  // Tracker state: the event FIFO and the ring of keys already handed out.
  logic [KBITS-1:0] ring_key [SDEPTH];
  int               ring_wr    = 0;
  int               ring_count = 0;
  logic [KBITS-1:0] fifo_key [QDEPTH];
  logic [PBITS-1:0] fifo_pay [QDEPTH];
  int               fifo_head  = 0;
  int               fifo_tail  = 0;
  int               fifo_fill  = 0;

  cmd_item_t        pending_cmds [$];
  track_result_t    expected_results [$];
  logic [KBITS-1:0] key_pool [POOL];
  int               sent_count  = 0;
  int               taken_count = 0;
  int               gap_left    = 0;
  int               quiet_left  = 0;
  int               stall_left  = 0;
  int               calm_left   = 0;
  int               err_count   = 0;

  function automatic bit key_in_ring(logic [KBITS-1:0] key);
    for (int i = 0; i < ring_count; i++) begin
      if (ring_key[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic track_result_t track_command(logic [1:0] cmd, logic [KBITS-1:0] key,
                                                  logic [PBITS-1:0] pay);
    track_result_t r;
    r.status  = STS_OK;
    r.success = 1'b0;
    r.dropped = 1'b0;
    r.key     = '0;
    r.pay     = '0;
    case (cmd)
      CMD_ENQUEUE: begin
        if (key == '0) begin
          r.status = STS_EMPTY_KEY;
        end else if (key_in_ring(key)) begin
          r.status = STS_SEEN;
        end else begin
          // A full FIFO loses its oldest event to make room.
          if (fifo_fill == QDEPTH) begin
            fifo_head = (fifo_head + 1) % QDEPTH;
            fifo_fill--;
            r.dropped = 1'b1;
          end
          fifo_key[fifo_tail] = key;
          fifo_pay[fifo_tail] = pay;
          fifo_tail = (fifo_tail + 1) % QDEPTH;
          fifo_fill++;
          r.success = 1'b1;
        end
      end
      CMD_DEQUEUE: begin
        if (fifo_fill == 0) begin
          r.status = STS_QUEUE_EMPTY;
        end else begin
          r.key = fifo_key[fifo_head];
          r.pay = fifo_pay[fifo_head];
          fifo_head = (fifo_head + 1) % QDEPTH;
          fifo_fill--;
          r.success = 1'b1;
          if (r.key != '0 && !key_in_ring(r.key)) begin
            ring_key[ring_wr] = r.key;
            ring_wr = (ring_wr + 1) % SDEPTH;
            if (ring_count < SDEPTH) ring_count++;
          end
        end
      end
      CMD_CLEAR_QUEUE: begin
        fifo_head = 0;
        fifo_tail = 0;
        fifo_fill = 0;
      end
      default: begin
        ring_wr    = 0;
        ring_count = 0;
      end
    endcase
    r.queued = QW'(fifo_fill);
    r.seen   = SW'(ring_count);
    return r;
  endfunction

  function automatic void push_cmd(cmd_e cmd, logic [KBITS-1:0] key, logic [PBITS-1:0] pay,
                                   bit drain);
    cmd_item_t it;
    it.cmd   = cmd;
    it.key   = key;
    it.pay   = pay;
    it.drain = drain;
    pending_cmds.push_back(it);
  endfunction

  function automatic logic [KBITS-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 70) return key_pool[$urandom_range(0, POOL - 1)];
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Sender: a new item is presented only once the previous one was taken.
  always @(negedge clk_i) begin
    if (rst_ni && sent_count == taken_count) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (pending_cmds.size() > 0 &&
                   !(pending_cmds[0].drain && expected_results.size() > 0)) begin
        command_i       <= pending_cmds[0].cmd;
        event_key_i     <= pending_cmds[0].key;
        event_payload_i <= pending_cmds[0].pay;
        in_valid_i      <= 1'b1;
        sent_count      <= sent_count + 1;
        void'(pending_cmds.pop_front());
        if (quiet_left > 0) begin
          quiet_left--;
          gap_left <= 0;
        end else begin
          if ($urandom_range(0, 99) < 3) quiet_left = $urandom_range(30, 80);
          gap_left <= pick_gap();
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stalls: mostly short, a few long, and some calm stretches.
  always @(negedge clk_i) begin : stall_gen
    int r;
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (calm_left > 0) begin
      out_stall_i <= 1'b0;
      calm_left   <= calm_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_stall_i <= 1'b0;
      end else if (r < 88) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(0, 3);
      end else if (r < 96) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(8, 30);
      end else begin
        out_stall_i <= 1'b0;
        calm_left   <= $urandom_range(40, 150);
      end
    end
  end

  // Accepted commands feed the tracker; accepted results are checked in order.
  always @(posedge clk_i) begin : monitor
    track_result_t exp_r;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(track_command(command_i, event_key_i, event_payload_i));
        taken_count <= taken_count + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          if (err_count < 10)
            $display("%0t: result with none expected: status %0d key %h", $time,
                     status_o, out_key_o);
          err_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (status_o !== exp_r.status || success_o !== exp_r.success ||
              dropped_oldest_o !== exp_r.dropped || out_key_o !== exp_r.key ||
              out_payload_o !== exp_r.pay || queued_total_o !== exp_r.queued ||
              seen_total_o !== exp_r.seen) begin
            if (err_count < 10) begin
              $display("%0t: mismatch, expected sts %0d ok %b drop %b key %h pay %h q %0d s %0d",
                       $time, exp_r.status, exp_r.success, exp_r.dropped, exp_r.key,
                       exp_r.pay, exp_r.queued, exp_r.seen);
              $display("%0t:           actual sts %0d ok %b drop %b key %h pay %h q %0d s %0d",
                       $time, status_o, success_o, dropped_oldest_o, out_key_o,
                       out_payload_o, queued_total_o, seen_total_o);
            end
            err_count++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int   mode;
    int   r;
    cmd_e cmd;

    for (int i = 0; i < POOL; i++) begin
      key_pool[i] = {$urandom, $urandom};
      if (key_pool[i] == '0) key_pool[i] = KBITS'(1);
    end

    // Directed part: empty queue, empty key, extreme keys, a seen key,
    // overflow with drop, a key dequeued twice, and both clear commands.
    push_cmd(CMD_DEQUEUE, '1, '1, 1'b0);
    push_cmd(CMD_ENQUEUE, '0, '1, 1'b0);
    push_cmd(CMD_ENQUEUE, '1, '1, 1'b0);
    push_cmd(CMD_ENQUEUE, 64'd1, '0, 1'b0);
    push_cmd(CMD_ENQUEUE, 64'h8000_0000_0000_0000, 32'h8000_0001, 1'b0);
    push_cmd(CMD_DEQUEUE, '0, '0, 1'b0);
    push_cmd(CMD_ENQUEUE, '1, 32'h1234_5678, 1'b0);
    push_cmd(CMD_DEQUEUE, '0, '0, 1'b0);
    for (int k = 2; k <= 9; k++) push_cmd(CMD_ENQUEUE, KBITS'(k), {$urandom}, 1'b0);
    push_cmd(CMD_CLEAR_QUEUE, '1, '1, 1'b0);
    push_cmd(CMD_ENQUEUE, 64'hA, 32'hA5A5_A5A5, 1'b0);
    push_cmd(CMD_ENQUEUE, 64'hA, 32'h5A5A_5A5A, 1'b0);
    push_cmd(CMD_DEQUEUE, '0, '0, 1'b0);
    push_cmd(CMD_DEQUEUE, '0, '0, 1'b0);
    push_cmd(CMD_CLEAR_SEEN, '0, '0, 1'b0);
    push_cmd(CMD_DEQUEUE, '0, '0, 1'b0);

    // Random part in phases that lean towards filling, draining, or neither.
    mode = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 60 == 0) mode = $urandom_range(0, 2);
      r = $urandom_range(0, 199);
      if (r < 2) cmd = CMD_CLEAR_SEEN;
      else if (r < 10) cmd = CMD_CLEAR_QUEUE;
      else if (mode == 1) cmd = (r < 160) ? CMD_ENQUEUE : CMD_DEQUEUE;
      else if (mode == 2) cmd = (r < 65) ? CMD_ENQUEUE : CMD_DEQUEUE;
      else cmd = (r < 108) ? CMD_ENQUEUE : CMD_DEQUEUE;
      push_cmd(cmd, pick_key(), $urandom, i == N_RANDOM / 2);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() > 0 || sent_count != taken_count ||
           expected_results.size() > 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
